// ===== hw/rtl/swhsr_pkg.sv =====
`timescale 1ns / 1ps

package swhsr_pkg;

	// frame layout: four data bytes then a checksum byte, msb first
	localparam int FRAME_BITS = 40;
	localparam int BIT_IDX_W  = 6;
	localparam int EDGE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int DATA_W     = 32;

	// stream and configuration port widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// configuration register reset values
	localparam logic [15:0] START_LOW_RST   = 16'd25000;
	localparam logic [7:0]  RELEASE_RST     = 8'd30;
	localparam logic [7:0]  RESP_LOW_RST    = 8'd40;
	localparam logic [7:0]  RESP_HIGH_RST   = 8'd80;
	localparam logic [7:0]  RESP_TAIL_RST   = 8'd50;
	localparam logic [7:0]  SAMPLE_DLY_RST  = 8'd30;
	localparam logic [7:0]  EDGE_TMO_RST    = 8'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LOW_TICKS    = 3'd0,
		REG_RELEASE_TICKS      = 3'd1,
		REG_RESPONSE_LOW_WAIT  = 3'd2,
		REG_RESPONSE_HIGH_WAIT = 3'd3,
		REG_RESPONSE_TAIL_WAIT = 3'd4,
		REG_BIT_SAMPLE_DELAY   = 3'd5,
		REG_EDGE_TIMEOUT       = 3'd6
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_CHECKSUM    = 2'd1,
		ST_NO_RESPONSE = 2'd2,
		ST_BIT_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_LOW = 4'd1,
		PH_RELEASE   = 4'd2,
		PH_RESP_LOW  = 4'd3,
		PH_RESP_HIGH = 4'd4,
		PH_TAIL      = 4'd5,
		PH_BIT_HIGH  = 4'd6,
		PH_BIT_DELAY = 4'd7,
		PH_BIT_LOW   = 4'd8
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  response_low_wait;
		logic [7:0]  response_high_wait;
		logic [7:0]  response_tail_wait;
		logic [7:0]  bit_sample_delay;
		logic [7:0]  edge_timeout;
	} cfg_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [7:0]  humidity_int;
		logic [7:0]  humidity_dec;
		logic [7:0]  temperature_int;
		logic [7:0]  temperature_dec;
	} res_t;

endpackage

// ===== hw/rtl/single_wire_humidity_sensor_reader.sv =====
`timescale 1ns / 1ps

// single-wire humidity/temperature sensor reader. each request on the s_ side
// is one microsecond sample of the sensor data line plus a start flag, and each
// one yields exactly one request on the m_ side with the line drive, busy,
// done, status and the last complete frame's four data bytes. a start while idle
// pulls the line low for start_low_ticks, releases it for release_ticks,
// checks the sensor's low then high answer, waits out the tail and receives
// 40 bits msb first; the fifth byte must match the 8-bit sum of the first
// four. status: 0 ok, 1 checksum error, 2 no response, 3 bit timeout; a no
// response or timeout keeps the previous data bytes. rate: one sample every
// clock while s_tready is high; the state update is a single pass from the
// state registers into the output register; a one-entry skid stage keeps
// s_tready high for one more sample while m_tready is low. configuration is
// written via cfg_* (always ready); the user must write only while idle, unchecked.
module single_wire_humidity_sensor_reader #(
	parameter int WAIT_WIDTH = 16  // phase timer width, 8 to 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [swhsr_pkg::IN_TDATA_W-1:0]     s_tdata,  // [0] line_level, [1] start_request
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
	// [12:5] humidity_int, [20:13] humidity_dec, [28:21] temperature_int,
	// [36:29] temperature_dec, [39:37] zero
	output logic [swhsr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swhsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import swhsr_pkg::*;

	cfg_t cfg;
	res_t res_next;   // result of the sample being accepted
	res_t res_out;    // result at the output register
	logic step;

	// register writes land in the cycle after they are presented
	assign cfg_ready = 1'b1;

	swhsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// state advances only on an accepted sample
	assign step = s_tvalid && s_tready;

	swhsr_fsm #(
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.line_level    (s_tdata[0]),
		.start_request (s_tdata[1]),
		.cfg           (cfg),
		.res           (res_next)
	);

	// output register plus skid entry
	swhsr_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res_next),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res_out)
	);

	// pack fields from the lowest bit up
	assign m_tdata = {3'b000,
		res_out.temperature_dec, res_out.temperature_int,
		res_out.humidity_dec, res_out.humidity_int,
		res_out.status, res_out.done_res, res_out.busy_res, res_out.drive_low};

endmodule

// ===== hw/rtl/swhsr_cfg.sv =====
`timescale 1ns / 1ps

module swhsr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_valid,
	input  logic [swhsr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]   wr_data,
	output swhsr_pkg::cfg_t                    cfg
);
	import swhsr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks    <= START_LOW_RST;
			cfg_q.release_ticks      <= RELEASE_RST;
			cfg_q.response_low_wait  <= RESP_LOW_RST;
			cfg_q.response_high_wait <= RESP_HIGH_RST;
			cfg_q.response_tail_wait <= RESP_TAIL_RST;
			cfg_q.bit_sample_delay   <= SAMPLE_DLY_RST;
			cfg_q.edge_timeout       <= EDGE_TMO_RST;
		end else if (wr_valid) begin
			unique case (cfg_idx_t'(wr_index))
				REG_START_LOW_TICKS:    cfg_q.start_low_ticks    <= wr_data;
				REG_RELEASE_TICKS:      cfg_q.release_ticks      <= wr_data[7:0];
				REG_RESPONSE_LOW_WAIT:  cfg_q.response_low_wait  <= wr_data[7:0];
				REG_RESPONSE_HIGH_WAIT: cfg_q.response_high_wait <= wr_data[7:0];
				REG_RESPONSE_TAIL_WAIT: cfg_q.response_tail_wait <= wr_data[7:0];
				REG_BIT_SAMPLE_DELAY:   cfg_q.bit_sample_delay   <= wr_data[7:0];
				REG_EDGE_TIMEOUT:       cfg_q.edge_timeout       <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/swhsr_fsm.sv =====
`timescale 1ns / 1ps

module swhsr_fsm #(
	parameter int WAIT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            line_level,
	input  logic            start_request,
	input  swhsr_pkg::cfg_t cfg,
	output swhsr_pkg::res_t res
);
	import swhsr_pkg::*;

	localparam int CW = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;
	localparam logic [WAIT_WIDTH-1:0] WMAX = '1;

	phase_t                  phase_q, phase_d;
	logic [WAIT_WIDTH-1:0]   wait_q, wait_d, wait_inc;
	logic [EDGE_W-1:0]       edge_q, edge_d;
	logic [BIT_IDX_W-1:0]    bit_q, bit_d, bit_inc;
	logic [FRAME_BITS-1:0]   frame_q, frame_d, frame_sh, frame_fin;
	logic [DATA_W-1:0]       data_q, data_d;
	logic [STATUS_W-1:0]     status_q, status_d;
	logic                    done_d;
	logic [15:0]             limit;
	logic                    elapsed, edge_late, bit_last;
	logic [7:0]              sum;

	// shared phase timer, saturating at the counter maximum
	always_comb begin
		wait_inc = (wait_q == WMAX) ? wait_q : wait_q + 1'b1;
		unique case (phase_q)
			PH_START_LOW: limit = cfg.start_low_ticks;
			PH_RELEASE:   limit = 16'(cfg.release_ticks);
			PH_RESP_LOW:  limit = 16'(cfg.response_low_wait);
			PH_RESP_HIGH: limit = 16'(cfg.response_high_wait);
			PH_TAIL:      limit = 16'(cfg.response_tail_wait);
			PH_BIT_DELAY: limit = 16'(cfg.bit_sample_delay);
			default:      limit = '0;
		endcase
		elapsed = (CW'(wait_inc) >= CW'(limit)) || (wait_inc == WMAX);
	end

	// frame bookkeeping and checksum
	always_comb begin
		edge_late = edge_q >= cfg.edge_timeout;
		frame_sh  = {frame_q[FRAME_BITS-2:0], line_level};
		bit_inc   = bit_q + 1'b1;
		bit_last  = 32'(bit_inc) >= 32'(FRAME_BITS);
		frame_fin = (phase_q == PH_BIT_DELAY) ? frame_sh : frame_q;
		sum = frame_fin[39:32] + frame_fin[31:24] + frame_fin[23:16] + frame_fin[15:8];
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		edge_d   = edge_q;
		bit_d    = bit_q;
		frame_d  = frame_q;
		data_d   = data_q;
		status_d = status_q;
		done_d   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_request) begin
					frame_d = '0;
					bit_d   = '0;
					edge_d  = '0;
					wait_d  = '0;
					phase_d = PH_START_LOW;
				end
			end
			PH_START_LOW, PH_RELEASE, PH_TAIL: begin
				wait_d = wait_inc;
				if (elapsed) begin
					wait_d = '0;
					if (phase_q == PH_START_LOW) begin
						phase_d = PH_RELEASE;
					end else if (phase_q == PH_RELEASE) begin
						phase_d = PH_RESP_LOW;
					end else begin
						bit_d   = '0;
						edge_d  = '0;
						phase_d = PH_BIT_HIGH;
					end
				end
			end
			PH_RESP_LOW, PH_RESP_HIGH: begin
				wait_d = wait_inc;
				if (elapsed) begin
					wait_d = '0;
					// expect low first, then high
					if (line_level == (phase_q == PH_RESP_HIGH)) begin
						phase_d = (phase_q == PH_RESP_LOW) ? PH_RESP_HIGH : PH_TAIL;
					end else begin
						phase_d  = PH_IDLE;
						status_d = ST_NO_RESPONSE;
						done_d   = 1'b1;
					end
				end
			end
			PH_BIT_HIGH, PH_BIT_LOW, PH_BIT_DELAY: begin
				if (phase_q == PH_BIT_DELAY && !elapsed) begin
					wait_d = wait_inc;
				end else if (phase_q == PH_BIT_HIGH && line_level) begin
					wait_d  = '0;
					phase_d = PH_BIT_DELAY;
				end else if (phase_q == PH_BIT_DELAY && line_level) begin
					frame_d = frame_sh;
					wait_d  = '0;
					phase_d = PH_BIT_LOW;
				end else if (phase_q == PH_BIT_DELAY || !line_level && phase_q == PH_BIT_LOW) begin
					// bit complete
					if (phase_q == PH_BIT_DELAY) begin
						frame_d = frame_sh;
					end
					bit_d  = bit_inc;
					wait_d = '0;
					if (bit_last) begin
						data_d   = frame_fin[FRAME_BITS-1:8];
						status_d = (sum == frame_fin[7:0]) ? ST_OK : ST_CHECKSUM;
						done_d   = 1'b1;
						phase_d  = PH_IDLE;
					end else begin
						edge_d  = '0;
						phase_d = PH_BIT_HIGH;
					end
				end else if (edge_late) begin
					wait_d   = '0;
					status_d = ST_BIT_TIMEOUT;
					done_d   = 1'b1;
					phase_d  = PH_IDLE;
				end else begin
					edge_d = edge_q + 1'b1;
				end
			end
			default: begin
				wait_d  = '0;
				phase_d = PH_IDLE;
			end
		endcase
	end

	// result fields, taken after this tick's update
	always_comb begin
		res.drive_low       = phase_d == PH_START_LOW;
		res.busy_res        = phase_d != PH_IDLE;
		res.done_res        = done_d;
		res.status          = status_d;
		res.humidity_int    = data_d[31:24];
		res.humidity_dec    = data_d[23:16];
		res.temperature_int = data_d[15:8];
		res.temperature_dec = data_d[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			edge_q   <= '0;
			bit_q    <= '0;
			frame_q  <= '0;
			data_q   <= '0;
			status_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			edge_q   <= edge_d;
			bit_q    <= bit_d;
			frame_q  <= frame_d;
			data_q   <= data_d;
			status_q <= status_d;
		end
	end

endmodule

// ===== hw/rtl/swhsr_out_skid.sv =====
`timescale 1ns / 1ps

module swhsr_out_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  swhsr_pkg::res_t in_res,
	output logic            out_valid,
	input  logic            out_ready,
	output swhsr_pkg::res_t out_res
);
	import swhsr_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_res_q, skid_res_q;
	logic push, pop;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && in_ready;
	assign pop      = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_res_q <= in_res;
			end else begin
				skid_res_q <= in_res;
			end
		end else if (pop && skid_valid_q) begin
			out_res_q <= skid_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// ===== hw/rtl/swhsr_checker.sv =====
`timescale 1ns / 1ps

module swhsr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [swhsr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// back-pressure on the input only when a result is already waiting
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a finishing tick always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
		else $error("done while busy");

	// the line is only driven during a read
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("line driven while idle");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (.*);
